/* rtl/lfsc_pkg.sv */
// ----------------------------------------------------------------------------
// lfsc_pkg: shared types and constants for the lidar frame checker
// Holds the header pattern, the frame layout, the queue item type, the
// hunter state type and the word-wide CRC-32 update matrix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfsc_pkg;

  // Frame layout.
  localparam int unsigned FrameLen  = 24;
  localparam int unsigned CrcWords  = 5;
  localparam int unsigned PosW      = 5;
  localparam int unsigned QueueDepth = 2;

  localparam logic [PosW-1:0] FirstPos = PosW'(4);
  localparam logic [PosW-1:0] LastPos  = PosW'(FrameLen - 1);

  // Word indexes inside the frame (byte position divided by four).
  localparam logic [2:0] WordFirst = 3'd1;
  localparam logic [2:0] WordDist  = 3'd2;
  localparam logic [2:0] WordAmp   = 3'd3;
  localparam logic [2:0] WordCheck = 3'(CrcWords);

  // Byte lanes inside a little-endian word.
  localparam logic [1:0] Lane0 = 2'd0;
  localparam logic [1:0] Lane1 = 2'd1;
  localparam logic [1:0] Lane2 = 2'd2;
  localparam logic [1:0] Lane3 = 2'd3;

  // Header bytes, in the order they arrive on the link.
  localparam logic [7:0] Sync0 = 8'h44;
  localparam logic [7:0] Sync1 = 8'h45;
  localparam logic [7:0] Sync2 = 8'h32;
  localparam logic [7:0] Sync3 = 8'h30;
  localparam logic [31:0] HeaderWord = {Sync3, Sync2, Sync1, Sync0};

  // CRC-32, non-reflected, MSB first, no final XOR.
  localparam logic [31:0] CrcPoly = 32'h04C1_1DB7;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  // Hunter states: header bytes matched so far, then inside a frame.
  typedef enum logic [2:0] {
    StHunt0,
    StHunt1,
    StHunt2,
    StHunt3,
    StFrame
  } lfsc_state_e;

  // One frame byte handed from the hunter to the checker.
  typedef struct packed {
    logic [7:0]      data;
    logic [PosW-1:0] pos;
  } lfsc_item_t;

  typedef logic [31:0][31:0] crc_cols_t;

  // Thirty-two shifts of the CRC register with the word already folded in.
  // Only used to build constants.
  function automatic logic [31:0] crc_shift32(logic [31:0] d);
    logic [31:0] r;
    r = d;
    for (int k = 0; k < 32; k++) begin
      r = r[31] ? ((r << 1) ^ CrcPoly) : (r << 1);
    end
    return r;
  endfunction

  // Response of the word update to each single set bit.
  function automatic crc_cols_t crc_make_cols();
    crc_cols_t cols;
    for (int i = 0; i < 32; i++) begin
      cols[i] = crc_shift32(32'(1) << i);
    end
    return cols;
  endfunction

  localparam crc_cols_t CrcCols = crc_make_cols();

  // CRC after the fixed header word, which every frame starts with.
  localparam logic [31:0] CrcHeader = crc_shift32(CrcInit ^ HeaderWord);

  // Word-wide CRC update: the update is linear in crc XOR word, so it is a
  // single XOR matrix over the 32 bits.
  function automatic logic [31:0] crc_apply(logic [31:0] crc, logic [31:0] word);
    logic [31:0] d;
    logic [31:0] r;
    d = crc ^ word;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (d[i]) begin
        r = r ^ CrcCols[i];
      end
    end
    return r;
  endfunction

endpackage

/* rtl/lfsc_byte_if.sv */
// ----------------------------------------------------------------------------
// lfsc_byte_if: received byte channel
// Valid/ready channel that carries one received byte per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lfsc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/lfsc_result_if.sv */
// ----------------------------------------------------------------------------
// lfsc_result_if: frame result channel
// Valid/ready channel that carries distance, amplitude and the CRC flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lfsc_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] distance_raw;
  logic [31:0] amplitude_raw;
  logic        crc_ok;

  modport source (output valid, output distance_raw, output amplitude_raw,
                  output crc_ok, input ready);
  modport sink (input valid, input distance_raw, input amplitude_raw,
                input crc_ok, output ready);
endinterface

/* rtl/lidar_frame_sync_crc32_check.sv */
// ----------------------------------------------------------------------------
// lidar_frame_sync_crc32_check: lidar frame sync and CRC-32 check
// Throughput: one byte per cycle while the queue has room; the CRC matrix
// updates a full word in the cycle its last byte is taken, so no byte waits on
// the CRC. Result path: the last frame byte passes through the queue and then
// the result register before the result is valid.
// Reset: asynchronous, active low; the hunter restarts at the header search,
// the queue empties and no result is pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lidar_frame_sync_crc32_check
  import lfsc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  lfsc_byte_if.sink        rx_i,
  lfsc_result_if.source    res_o
);

  logic       push_valid, push_ready;
  lfsc_item_t push_item;
  logic       pop_valid, pop_ready;
  lfsc_item_t pop_item;

  // Front: header hunt and byte tagging.
  lfsc_hunter u_hunter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (rx_i.valid),
    .rx_byte_i    (rx_i.rx_byte),
    .rx_ready_o   (rx_i.ready),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  // Queue between the two halves.
  lfsc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  // Back: word assembly, CRC and result.
  lfsc_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (pop_valid),
    .in_item_i       (pop_item),
    .in_ready_o      (pop_ready),
    .out_valid_o     (res_o.valid),
    .out_distance_o  (res_o.distance_raw),
    .out_amplitude_o (res_o.amplitude_raw),
    .out_crc_ok_o    (res_o.crc_ok),
    .out_ready_i     (res_o.ready)
  );

endmodule

/* rtl/lfsc_hunter.sv */
// ----------------------------------------------------------------------------
// lfsc_hunter: header hunter and byte classifier
// Searches the byte stream for the frame header, then tags each following
// frame byte with its position and pushes it toward the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfsc_hunter
  import lfsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  input  logic [7:0] rx_byte_i,
  output logic       rx_ready_o,
  output logic       push_valid_o,
  output lfsc_item_t push_item_o,
  input  logic       push_ready_i
);

  lfsc_state_e     state_q, state_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            accept;
  logic [7:0]      expect_byte;

  assign accept = rx_valid_i && rx_ready_o;

  // Header byte that the current hunt state waits for.
  always_comb begin
    case (state_q)
      StHunt0: expect_byte = Sync0;
      StHunt1: expect_byte = Sync1;
      StHunt2: expect_byte = Sync2;
      StHunt3: expect_byte = Sync3;
      default: expect_byte = Sync0;
    endcase
  end

  // Next state and frame position.
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    if (accept) begin
      case (state_q)
        StFrame: begin
          if (pos_q == LastPos) begin
            state_d = StHunt0;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + PosW'(1);
          end
        end
        StHunt0, StHunt1, StHunt2, StHunt3: begin
          if (rx_byte_i == expect_byte) begin
            if (state_q == StHunt3) begin
              state_d = StFrame;
              pos_d   = FirstPos;
            end else begin
              state_d = lfsc_state_e'(state_q + 3'd1);
            end
          end else if (rx_byte_i == Sync0) begin
            state_d = StHunt1;
          end else begin
            state_d = StHunt0;
          end
        end
        default: begin
          state_d = StHunt0;
          pos_d   = '0;
        end
      endcase
    end
  end

  // Outputs: hunting bytes are consumed here, frame bytes go to the queue.
  always_comb begin
    push_item_o.data = rx_byte_i;
    push_item_o.pos  = pos_q;
    if (state_q == StFrame) begin
      rx_ready_o   = push_ready_i;
      push_valid_o = rx_valid_i;
    end else begin
      rx_ready_o   = 1'b1;
      push_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StHunt0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

endmodule

/* rtl/lfsc_queue.sv */
// ----------------------------------------------------------------------------
// lfsc_queue: short queue between hunter and checker
// Two-entry first-in first-out buffer of tagged frame bytes, so that the
// hunter keeps taking bytes while the checker waits on its output, until the buffer is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfsc_queue
  import lfsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  input  lfsc_item_t push_item_i,
  output logic       push_ready_o,
  output logic       pop_valid_o,
  output lfsc_item_t pop_item_o,
  input  logic       pop_ready_i
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  lfsc_item_t      entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* rtl/lfsc_checker.sv */
// ----------------------------------------------------------------------------
// lfsc_checker: word assembly, CRC and result register
// Packs frame bytes into little-endian words, runs words 1 to 4 through the
// CRC after the fixed header word, keeps distance and amplitude and
// registers one result per frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfsc_checker
  import lfsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  lfsc_item_t  in_item_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  output logic [31:0] out_distance_o,
  output logic [31:0] out_amplitude_o,
  output logic        out_crc_ok_o,
  input  logic        out_ready_i
);

  logic [23:0] gather_q, gather_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] dist_q, dist_d;
  logic [31:0] amp_q, amp_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_dist_q, out_amp_q;
  logic        out_ok_q;

  logic [1:0]  lane;
  logic [2:0]  idx;
  logic [31:0] word;
  logic [31:0] crc_base;
  logic        emits;
  logic        take;

  assign lane     = in_item_i.pos[1:0];
  assign idx      = in_item_i.pos[PosW-1:2];
  assign word     = {in_item_i.data, gather_q};
  assign crc_base = (idx == WordFirst) ? CrcHeader : crc_q;
  assign emits    = (in_item_i.pos == LastPos);

  // A byte that completes a frame waits for a free result register.
  assign in_ready_o = !emits || !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  // Word assembly, CRC and field holds.
  always_comb begin
    gather_d = gather_q;
    crc_d    = crc_q;
    dist_d   = dist_q;
    amp_d    = amp_q;
    if (take) begin
      case (lane)
        Lane0: gather_d = {16'h0000, in_item_i.data};
        Lane1: gather_d[15:8] = in_item_i.data;
        Lane2: gather_d[23:16] = in_item_i.data;
        Lane3: begin
          if (idx == WordDist) begin
            dist_d = word;
          end
          if (idx == WordAmp) begin
            amp_d = word;
          end
          if (idx != WordCheck) begin
            crc_d = crc_apply(crc_base, word);
          end
        end
        default: gather_d = gather_q;
      endcase
    end
  end

  // Result register handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (take && emits) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gather_q    <= '0;
      crc_q       <= CrcInit;
      dist_q      <= '0;
      amp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      gather_q    <= gather_d;
      crc_q       <= crc_d;
      dist_q      <= dist_d;
      amp_q       <= amp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded when the last frame byte is taken.
  always_ff @(posedge clk_i) begin
    if (take && emits) begin
      out_dist_q <= dist_q;
      out_amp_q  <= amp_q;
      out_ok_q   <= (crc_q == word);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_distance_o  = out_dist_q;
  assign out_amplitude_o = out_amp_q;
  assign out_crc_ok_o    = out_ok_q;

endmodule
